// File: rtl/gb5_pkg.sv
// shared types and constants for the 5x5 blur stream
package gb5_pkg;

	localparam int PIX_W = 8;
	localparam int SUM_W = 24;
	localparam int DIV_W = 16;
	localparam int WID_W = 12;

	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_C0    = 3'd1;
	localparam logic [2:0] REG_C1    = 3'd2;
	localparam logic [2:0] REG_C2    = 3'd3;
	localparam logic [2:0] REG_C3    = 3'd4;
	localparam logic [2:0] REG_C4    = 3'd5;
	localparam logic [2:0] REG_C5    = 3'd6;
	localparam logic [2:0] REG_DIV   = 3'd7;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic [7:0] blurred;
		logic       last_in_run;
		logic       frame_end;
	} out_item_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;        // take new item into window
		logic clear_win;   // column 0: clear window before shift
		logic shift_zero;  // shift a zero column in
		logic start_div;   // start a divide on current window
		logic push;        // quotient ready: present result
		logic last;
		logic fend;
	} gb5_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} gb5_sts_t;

	function automatic logic [2:0] coef_sel(input int dy, input int dx);
		int a, b;
		a = dy < 0 ? -dy : dy;
		b = dx < 0 ? -dx : dx;
		if (a == 0 && b == 0) return 3'd5;
		if ((a == 0 && b == 1) || (a == 1 && b == 0)) return 3'd4;
		if ((a == 0 && b == 2) || (a == 2 && b == 0)) return 3'd2;
		if (a == 1 && b == 1) return 3'd3;
		if (a == 2 && b == 2) return 3'd0;
		return 3'd1;
	endfunction

endpackage

// File: rtl/gb5_div.sv
// restoring divider, one quotient bit per cycle, saturating to 255
module gb5_div import gb5_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [7:0]       quot
);
	logic [SUM_W-1:0] q_q;
	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] dv_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic [DIV_W:0]   trial;

	assign trial = {rem_q[DIV_W-1:0], q_q[SUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dv_q}) begin
				rem_q <= trial - {1'b0, dv_q};
				q_q   <= {q_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = (dv_q == '0 || q_q[SUM_W-1:8] != '0) ? 8'hff : q_q[7:0];
endmodule

// File: rtl/gb5_datapath.sv
// line stores, 5x5 window, weighted sum, divider and output register
module gb5_datapath import gb5_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gb5_cmd_t                     cmd,
	output gb5_sts_t                     sts,
	input  logic [7:0]                   pix,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  logic [1:0]                   rows_seen,
	input  logic [7:0]                   coef [6],
	input  logic [DIV_W-1:0]             divisor,
	output out_item_t                    out_item,
	output logic                         out_valid,
	input  logic                         out_ready
);
	logic [7:0] mem0 [MAX_WIDTH];
	logic [7:0] mem1 [MAX_WIDTH];
	logic [7:0] mem2 [MAX_WIDTH];
	logic [7:0] mem3 [MAX_WIDTH];
	logic [7:0] rd_q [4];
	logic [7:0] v [4];
	logic [7:0] win_q [5][5];
	logic [SUM_W-1:0] prod_s1 [25];
	logic [SUM_W-1:0] row_s2 [5];
	logic [SUM_W-1:0] sum_q;
	logic [2:0] go_q;
	logic       div_start_q, div_done;
	logic [7:0] quot;

	// read port: the controller presents the address in the cycle before the load
	always_ff @(posedge clk) begin
		rd_q[0] <= mem0[col];
		rd_q[1] <= mem1[col];
		rd_q[2] <= mem2[col];
		rd_q[3] <= mem3[col];
		if (cmd.load) begin
			mem0[col] <= pix;
			mem1[col] <= v[0];
			mem2[col] <= v[1];
			mem3[col] <= v[2];
		end
	end

	always_comb begin
		v[0] = (rows_seen > 2'd0) ? rd_q[0] : '0;
		v[1] = (rows_seen > 2'd1) ? rd_q[1] : '0;
		v[2] = (rows_seen > 2'd2) ? rd_q[2] : '0;
		v[3] = (rows_seen > 2'd2) ? rd_q[3] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 5; r++)
				for (int c = 0; c < 5; c++) win_q[r][c] <= '0;
		end else if (cmd.load || cmd.shift_zero) begin
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 4; c++)
					win_q[r][c] <= cmd.clear_win ? 8'd0 : win_q[r][c+1];
			end
			win_q[0][4] <= cmd.load ? v[3] : 8'd0;
			win_q[1][4] <= cmd.load ? v[2] : 8'd0;
			win_q[2][4] <= cmd.load ? v[1] : 8'd0;
			win_q[3][4] <= cmd.load ? v[0] : 8'd0;
			win_q[4][4] <= cmd.load ? pix  : 8'd0;
		end
	end

	// products registered, then row sums, then the total, then divide
	always_ff @(posedge clk) begin
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 5; c++)
				prod_s1[r*5+c] <= SUM_W'(win_q[r][c]) * SUM_W'(coef[coef_sel(r-2, c-2)]);
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 5; r++)
			row_s2[r] <= prod_s1[r*5] + prod_s1[r*5+1] + prod_s1[r*5+2] +
				prod_s1[r*5+3] + prod_s1[r*5+4];
	end

	always_ff @(posedge clk) begin
		sum_q <= row_s2[0] + row_s2[1] + row_s2[2] + row_s2[3] + row_s2[4];
	end

	// start follows the window through product, row sum and total stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q        <= '0;
			div_start_q <= 1'b0;
		end else begin
			go_q        <= {go_q[1:0], cmd.start_div};
			div_start_q <= go_q[2];
		end
	end

	gb5_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .dividend(sum_q),
		.divisor(divisor), .done(div_done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.push) out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) out_item <= '{blurred: quot, last_in_run: cmd.last, frame_end: cmd.fend};
	end

	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid && !out_ready;
endmodule

// File: rtl/gb5_ctrl.sv
// sequencer: read, load, then up to three blur/divide/output passes
module gb5_ctrl import gb5_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  in_item_t                     in_item,
	input  logic [WID_W-1:0]             image_width,
	output gb5_cmd_t                     cmd,
	input  gb5_sts_t                     sts,
	output logic [7:0]                   pix,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output logic [1:0]                   rows_seen
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_PUSH = 3'd4;
	localparam logic [2:0] S_NEXT = 3'd5;

	logic [2:0]    state_q;
	logic [AW:0]   colpos_q;
	logic [1:0]    rows_q, drain_q, total_q, n_q;
	logic          drain_item_q, lastc_q;
	logic [7:0]    pix_q;
	logic [AW:0]   w, cc;

	always_comb begin
		if (image_width < WID_W'(5)) w = (AW+1)'(5);
		else if ({{(AW+1){1'b0}}, image_width} > (AW+1+WID_W)'(MAX_WIDTH))
			w = (AW+1)'(MAX_WIDTH);
		else w = (AW+1)'(image_width);
		cc = (colpos_q >= w) ? w - 1'b1 : colpos_q;
	end

	assign col       = cc[AW-1:0];
	assign pix       = pix_q;
	assign rows_seen = rows_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load      = (state_q == S_LOAD);
		cmd.clear_win = (state_q == S_LOAD) && (cc == '0);
		cmd.shift_zero = (state_q == S_NEXT) && (n_q < total_q);
		cmd.start_div = ((state_q == S_LOAD) && total_q != 2'd0) ||
			((state_q == S_NEXT) && (n_q < total_q));
		cmd.push      = (state_q == S_PUSH) && !sts.out_busy;
		cmd.last      = (n_q + 2'd1 == total_q);
		cmd.fend      = cmd.last && lastc_q && drain_item_q && drain_q == 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			colpos_q <= '0;
			rows_q <= '0;
			drain_q <= '0;
			total_q <= '0;
			n_q <= '0;
			drain_item_q <= 1'b0;
			lastc_q <= 1'b0;
			pix_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					drain_item_q <= in_item.kind == KIND_DRAIN;
					pix_q   <= (in_item.kind == KIND_DRAIN) ? 8'd0 : in_item.pixel;
					state_q <= S_READ;
				end
				S_READ: begin
					lastc_q <= (cc == w - 1'b1);
					total_q <= (rows_q >= 2'd2 && cc >= (AW+1)'(2)) ?
						((cc == w - 1'b1) ? 2'd3 : 2'd1) : 2'd0;
					n_q <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: state_q <= (total_q != 2'd0) ? S_WAIT : S_NEXT;
				S_WAIT: if (sts.div_done) state_q <= S_PUSH;
				S_PUSH: if (!sts.out_busy) begin
					n_q <= n_q + 2'd1;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (n_q < total_q) state_q <= S_WAIT;
					else begin
						state_q <= S_IDLE;
						if (lastc_q) begin
							colpos_q <= '0;
							if (drain_item_q && drain_q == 2'd1) begin
								rows_q <= '0;
								drain_q <= '0;
							end else begin
								if (rows_q != 2'd3) rows_q <= rows_q + 2'd1;
								drain_q <= drain_item_q ? 2'd1 : 2'd0;
							end
						end else colpos_q <= cc + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/gaussian_blur_5x5_stream.sv
// top level of the 5x5 gaussian blur stream
//
// in channel: in_valid/in_ready carry one item {kind, pixel} in raster order;
// a drain item (kind=1) acts as a zero pixel, two drain rows end a frame.
// out channel: out_valid/out_ready carry {blurred, last_in_run, frame_end};
// an item yields zero, one or three results (three at the row's last column).
// apb port writes image_width, six coefficients and divisor at 4*index.
// sequencing: each item passes the read and load steps; each result then
// waits on the 24-step divider behind the product, row sum and total stages.
// the line stores are one sram per line with a registered read port.
// reset clears row/column counters and the window; the line stores are
// not cleared, rows above the frame are masked by the row count.
// if the receiver stalls, the sequencer holds in its push step, so a new
// result is not pushed until the pending one has left the output register.
module gaussian_blur_5x5_stream import gb5_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [WID_W-1:0] width_q;
	logic [7:0]       coef_q [6];
	logic [DIV_W-1:0] div_q;
	gb5_cmd_t         cmd;
	gb5_sts_t         sts;
	logic [7:0]       pix;
	logic [$clog2(MAX_WIDTH)-1:0] col;
	logic [1:0]       rows_seen;
	logic [2:0]       ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd640;
			coef_q[0] <= 8'd2;  coef_q[1] <= 8'd4;  coef_q[2] <= 8'd5;
			coef_q[3] <= 8'd9;  coef_q[4] <= 8'd12; coef_q[5] <= 8'd15;
			div_q <= 16'd159;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_WIDTH: width_q <= pwdata[WID_W-1:0];
				REG_C0:    coef_q[0] <= pwdata[7:0];
				REG_C1:    coef_q[1] <= pwdata[7:0];
				REG_C2:    coef_q[2] <= pwdata[7:0];
				REG_C3:    coef_q[3] <= pwdata[7:0];
				REG_C4:    coef_q[4] <= pwdata[7:0];
				REG_C5:    coef_q[5] <= pwdata[7:0];
				REG_DIV:   div_q <= pwdata[DIV_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_WIDTH: prdata = {20'd0, width_q};
			REG_C0:    prdata = {24'd0, coef_q[0]};
			REG_C1:    prdata = {24'd0, coef_q[1]};
			REG_C2:    prdata = {24'd0, coef_q[2]};
			REG_C3:    prdata = {24'd0, coef_q[3]};
			REG_C4:    prdata = {24'd0, coef_q[4]};
			REG_C5:    prdata = {24'd0, coef_q[5]};
			REG_DIV:   prdata = {16'd0, div_q};
			default:   prdata = '0;
		endcase
	end

	gb5_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .image_width(width_q), .cmd(cmd), .sts(sts),
		.pix(pix), .col(col), .rows_seen(rows_seen)
	);

	gb5_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .pix(pix), .col(col),
		.rows_seen(rows_seen), .coef(coef_q), .divisor(div_q),
		.out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
	);
endmodule
